@@ rtl/btr_pkg.sv @@
// Shared types and constants for the bitmap text renderer.
// Used by btr_ctrl, btr_datapath and the bitmap_text_renderer top level.
// No dependencies.
`default_nettype none

package btr_pkg;

  // Glyph geometry that does not vary.
  localparam int GLYPH_W     = 8;
  localparam int GLYPH_SHIFT = 3;

  // Row counters are sized for the tallest supported glyph (32 rows).
  localparam int ROW_CNT_W = 6;

  localparam int COLOR_W = 32;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_DRAW    = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEXT_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_TEXT_ROWS    = 2'd1;
  localparam logic [1:0] CFG_FG_COLOR     = 2'd2;
  localparam logic [1:0] CFG_BG_COLOR     = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]         RST_TEXT_COLUMNS = 8'd80;
  localparam logic [7:0]         RST_TEXT_ROWS    = 8'd40;
  localparam logic [COLOR_W-1:0] RST_FG_COLOR     = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] RST_BG_COLOR     = 32'h0000_0000;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 accept;
    logic                 rd_en;
    logic                 load;
    logic                 done;
    logic [ROW_CNT_W-1:0] rd_row;
    logic [ROW_CNT_W-1:0] emit_row;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic draw_go;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/btr_ctrl.sv @@
// Controller for the bitmap text renderer: state machine, glyph row counters
// and the output valid flag. Depends on btr_pkg.
`default_nettype none

module btr_ctrl #(
  parameter int GLYPH_HEIGHT = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire btr_pkg::dp_stat_t stat,
  output btr_pkg::ctl_cmd_t      cmd
);
  import btr_pkg::*;

  localparam logic [ROW_CNT_W-1:0] ROWS_V = ROW_CNT_W'(GLYPH_HEIGHT);
  localparam logic [ROW_CNT_W-1:0] LAST_V = ROW_CNT_W'(GLYPH_HEIGHT - 1);

  state_t               state_r, state_nxt;
  logic [ROW_CNT_W-1:0] rd_row_r, rd_row_nxt;
  logic [ROW_CNT_W-1:0] emit_row_r, emit_row_nxt;
  logic                 data_valid_r, data_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic in_fire;
  logic load;
  logic rd_en;
  logic done;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && stat.draw_go) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // Outputs and commands. A read row moves to the output register when the
  // register is free or being emptied; the next read is issued in the same
  // cycle, so one row leaves per cycle unless the output stalls.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    in_fire  = in_valid && in_ready;
    load     = (state_r == ST_RUN) && data_valid_r && (!out_valid_r || out_ready);
    rd_en    = (state_r == ST_RUN) && (rd_row_r != ROWS_V) && (!data_valid_r || load);
    done     = load && (emit_row_r == LAST_V);

    cmd.accept   = in_fire;
    cmd.rd_en    = rd_en;
    cmd.load     = load;
    cmd.done     = done;
    cmd.rd_row   = rd_row_r;
    cmd.emit_row = emit_row_r;

    out_valid = out_valid_r;
  end

  // Row counters, read data flag and output valid flag.
  always_comb begin
    rd_row_nxt     = rd_row_r;
    emit_row_nxt   = emit_row_r;
    data_valid_nxt = data_valid_r;
    out_valid_nxt  = out_valid_r;

    if (in_fire) begin
      rd_row_nxt   = '0;
      emit_row_nxt = '0;
    end else begin
      if (rd_en) begin
        rd_row_nxt = rd_row_r + 1'b1;
      end
      if (load) begin
        emit_row_nxt = emit_row_r + 1'b1;
      end
    end

    if (rd_en) begin
      data_valid_nxt = 1'b1;
    end else if (load) begin
      data_valid_nxt = 1'b0;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_row_r     <= '0;
      emit_row_r   <= '0;
      data_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_row_r     <= rd_row_nxt;
      emit_row_r   <= emit_row_nxt;
      data_valid_r <= data_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // The read counter never runs past the glyph height.
  a_rd_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_row_r <= ROWS_V)
    else $error("glyph read counter beyond glyph height");

  // While drawing, reads lead emitted rows by exactly the row held in read data.
  a_rows_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rd_row_r == ROW_CNT_W'(emit_row_r + data_valid_r)))
    else $error("read and emit row counters out of step");

  // The last row of a character returns to idle with that row on the output.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("last glyph row did not return to idle with output valid");

  // No stale glyph row is held while idle.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !data_valid_r)
    else $error("read data flagged valid while idle");

endmodule

`default_nettype wire

@@ rtl/btr_datapath.sv @@
// Datapath for the bitmap text renderer: configuration registers, cursor,
// font memory and the output register. Depends on btr_pkg.
`default_nettype none

module btr_datapath #(
  parameter int GLYPH_HEIGHT = 12,
  parameter int CHAR_CODES   = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [btr_pkg::COLOR_W-1:0]      cfg_data,
  input  wire logic [1:0]                       in_operation,
  input  wire logic [7:0]                       in_char_code,
  input  wire logic [3:0]                       in_glyph_row,
  input  wire logic [7:0]                       in_glyph_bits,
  input  wire btr_pkg::ctl_cmd_t                cmd,
  output btr_pkg::dp_stat_t                     stat,
  output logic [10:0]                           out_pixel_x,
  output logic [11:0]                           out_pixel_y,
  output logic [btr_pkg::GLYPH_W-1:0][btr_pkg::COLOR_W-1:0] out_colors,
  output logic                                  out_last_row
);
  import btr_pkg::*;

  localparam int RW         = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int CODE_W     = $clog2(CHAR_CODES);
  localparam int FONT_DEPTH = CHAR_CODES << RW;
  localparam int ADDR_W     = CODE_W + RW;

  localparam logic [8:0]           CODES_V = 9'(CHAR_CODES);
  localparam logic [ROW_CNT_W-1:0] GH_V    = ROW_CNT_W'(GLYPH_HEIGHT);

  // Configuration registers.
  logic [7:0]         text_columns_r;
  logic [7:0]         text_rows_r;
  logic [COLOR_W-1:0] fg_color_r;
  logic [COLOR_W-1:0] bg_color_r;

  // Cursor state.
  logic [7:0] cursor_column_r, cursor_column_nxt;
  logic [7:0] cursor_row_r, cursor_row_nxt;
  logic       screen_full_r, screen_full_nxt;

  // Character being drawn.
  logic [CODE_W-1:0] code_r;
  logic [13:0]       ybase_r;

  // Font memory and its registered read data.
  logic [7:0]        font_mem [FONT_DEPTH];
  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Output register.
  logic [10:0]                           pixel_x_r;
  logic [11:0]                           pixel_y_r;
  logic [GLYPH_W-1:0][COLOR_W-1:0]       colors_r;
  logic [GLYPH_W-1:0][COLOR_W-1:0]       colors_nxt;
  logic                                  last_row_r;

  // Decode of the input transaction.
  logic                 op_draw, op_load, op_restart;
  logic                 code_ok, row_ok, blocked, is_newline, load_ok;
  logic [ROW_CNT_W-1:0] grow_ext;

  // Cursor arithmetic.
  logic [7:0] row_inc, col_inc;
  logic       full_on_inc, wrap;

  always_comb begin
    op_draw    = (in_operation == OP_DRAW);
    op_load    = (in_operation == OP_LOAD);
    op_restart = (in_operation == OP_RESTART);
    grow_ext   = ROW_CNT_W'(in_glyph_row);
    code_ok    = ({1'b0, in_char_code} < CODES_V);
    row_ok     = (grow_ext < GH_V);
    blocked    = screen_full_r || (cursor_row_r >= text_rows_r);
    is_newline = (in_char_code == NEWLINE_CODE);
    load_ok    = op_load && code_ok && row_ok;

    stat.draw_go = op_draw && !blocked && !is_newline && code_ok;

    wr_addr = {in_char_code[CODE_W-1:0], grow_ext[RW-1:0]};
    rd_addr = {code_r, cmd.rd_row[RW-1:0]};
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_columns_r <= RST_TEXT_COLUMNS;
      text_rows_r    <= RST_TEXT_ROWS;
      fg_color_r     <= RST_FG_COLOR;
      bg_color_r     <= RST_BG_COLOR;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEXT_COLUMNS: text_columns_r <= cfg_data[7:0];
        CFG_TEXT_ROWS:    text_rows_r    <= cfg_data[7:0];
        CFG_FG_COLOR:     fg_color_r     <= cfg_data;
        CFG_BG_COLOR:     bg_color_r     <= cfg_data;
      endcase
    end
  end

  // Cursor update: restart, newline, or advance after the last glyph row.
  always_comb begin
    row_inc     = cursor_row_r + 8'd1;
    full_on_inc = (row_inc >= text_rows_r);
    col_inc     = cursor_column_r + 8'd1;
    wrap        = (col_inc >= text_columns_r) || (col_inc == 8'd0);

    cursor_column_nxt = cursor_column_r;
    cursor_row_nxt    = cursor_row_r;
    screen_full_nxt   = screen_full_r;

    priority if (cmd.accept && op_restart) begin
      cursor_column_nxt = 8'd0;
      cursor_row_nxt    = 8'd0;
      screen_full_nxt   = 1'b0;
    end else if (cmd.accept && op_draw && !blocked && is_newline) begin
      cursor_column_nxt = 8'd0;
      cursor_row_nxt    = row_inc;
      screen_full_nxt   = screen_full_r || full_on_inc;
    end else if (cmd.done) begin
      if (wrap) begin
        cursor_column_nxt = 8'd0;
        cursor_row_nxt    = row_inc;
        screen_full_nxt   = screen_full_r || full_on_inc;
      end else begin
        cursor_column_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_column_r <= 8'd0;
      cursor_row_r    <= 8'd0;
      screen_full_r   <= 1'b0;
    end else begin
      cursor_column_r <= cursor_column_nxt;
      cursor_row_r    <= cursor_row_nxt;
      screen_full_r   <= screen_full_nxt;
    end
  end

  // Character and vertical base captured at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_r  <= in_char_code[CODE_W-1:0];
      ybase_r <= {6'd0, cursor_row_r} * {8'd0, GH_V};
    end
  end

  // Font memory: one write port for glyph loads, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept && load_ok) begin
      font_mem[wr_addr] <= in_glyph_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= font_mem[rd_addr];
    end
  end

  // Pixel colors, bit 7 of the glyph row leftmost.
  always_comb begin
    for (int k = 0; k < GLYPH_W; k++) begin
      colors_nxt[k] = rdata_r[GLYPH_W-1-k] ? fg_color_r : bg_color_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_x_r  <= 11'(cursor_column_r) << GLYPH_SHIFT;
      pixel_y_r  <= 12'(ybase_r + 14'(cmd.emit_row));
      colors_r   <= colors_nxt;
      last_row_r <= cmd.done;
    end
  end

  assign out_pixel_x  = pixel_x_r;
  assign out_pixel_y  = pixel_y_r;
  assign out_colors   = colors_r;
  assign out_last_row = last_row_r;

endmodule

`default_nettype wire

@@ rtl/bitmap_text_renderer.sv @@
// Top level of the bitmap text renderer: text-mode character generator.
// Instantiates btr_ctrl and btr_datapath; depends on btr_pkg.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     operation, char_code, glyph_row, glyph_bits
//   out      out_valid / out_ready   pixel_x, pixel_y, color_0..7, last_row
//   cfg      cfg_wr_en               cfg_index, cfg_data
//
// A drawn character produces GLYPH_HEIGHT rows, one per cycle from the single
// font memory read port while the output is not stalled; the next transaction
// is taken once the last row of a drawn character enters the output register.
// Loads, restarts, newlines and dropped characters leave the block idle.
// Reset is synchronous, active low; the font memory is not cleared.
// A stalled output holds the current row and pauses the font reads.
`default_nettype none

module bitmap_text_renderer #(
  parameter int GLYPH_HEIGHT = 12,
  parameter int CHAR_CODES   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [3:0]  in_glyph_row,
  input  wire logic [7:0]  in_glyph_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      out_pixel_x,
  output logic [11:0]      out_pixel_y,
  output logic [31:0]      out_color_0,
  output logic [31:0]      out_color_1,
  output logic [31:0]      out_color_2,
  output logic [31:0]      out_color_3,
  output logic [31:0]      out_color_4,
  output logic [31:0]      out_color_5,
  output logic [31:0]      out_color_6,
  output logic [31:0]      out_color_7,
  output logic             out_last_row
);
  import btr_pkg::*;

  ctl_cmd_t                        cmd;
  dp_stat_t                        stat;
  logic [GLYPH_W-1:0][COLOR_W-1:0] colors;

  btr_ctrl #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  btr_datapath #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .CHAR_CODES   (CHAR_CODES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_glyph_row  (in_glyph_row),
    .in_glyph_bits (in_glyph_bits),
    .cmd           (cmd),
    .stat          (stat),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_colors    (colors),
    .out_last_row  (out_last_row)
  );

  // Leftmost pixel first.
  assign out_color_0 = colors[0];
  assign out_color_1 = colors[1];
  assign out_color_2 = colors[2];
  assign out_color_3 = colors[3];
  assign out_color_4 = colors[4];
  assign out_color_5 = colors[5];
  assign out_color_6 = colors[6];
  assign out_color_7 = colors[7];

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the bitmap text renderer.
// It predicts every glyph row from its own model of the cursor, the font store and the
// registers. Depends on btr_pkg and the bitmap_text_renderer RTL.
`timescale 1ns / 1ps

module tb;
  import btr_pkg::*;

  localparam int GLYPH_ROWS    = 12;
  localparam int CHAR_COUNT    = 256;
  localparam int SETTLE_CYCLES = GLYPH_ROWS + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 240;
  localparam int RANDOM_PHASES = 6;

  // One glyph row as it leaves the block.
  typedef struct packed {
    logic [10:0]      pixel_x;
    logic [11:0]      pixel_y;
    logic [7:0][31:0] color;
    logic             last_row;
  } pixel_row_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        cfg_wr_en     = 1'b0;
  logic [1:0]  cfg_index     = CFG_TEXT_COLUMNS;
  logic [31:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation  = OP_DRAW;
  logic [7:0]  in_char_code  = '0;
  logic [3:0]  in_glyph_row  = '0;
  logic [7:0]  in_glyph_bits = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [10:0] out_pixel_x;
  logic [11:0] out_pixel_y;
  logic [31:0] out_color_0, out_color_1, out_color_2, out_color_3;
  logic [31:0] out_color_4, out_color_5, out_color_6, out_color_7;
  logic        out_last_row;

  // Mirror of the block's state and registers.
  logic [7:0]            font_mem [CHAR_COUNT][GLYPH_ROWS];
  logic [GLYPH_ROWS-1:0] rows_loaded [CHAR_COUNT] = '{default: '0};
  logic [7:0]            drawable_codes [$];
  logic [7:0]            cur_col    = '0;
  logic [7:0]            cur_row    = '0;
  logic                  frame_full = 1'b0;
  logic [7:0]            cols_cfg   = RST_TEXT_COLUMNS;
  logic [7:0]            rows_cfg   = RST_TEXT_ROWS;
  logic [31:0]           fg_cfg     = RST_FG_COLOR;
  logic [31:0]           bg_cfg     = RST_BG_COLOR;

  pixel_row_t pending_rows [$];
  int         mismatch_count = 0;
  int         rows_checked   = 0;
  int         items_sent     = 0;
  int         cycle_count    = 0;
  logic       idle_en        = 1'b1;
  logic       hold_request   = 1'b0;

  bitmap_text_renderer #(
    .GLYPH_HEIGHT(GLYPH_ROWS),
    .CHAR_CODES  (CHAR_COUNT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .in_glyph_row (in_glyph_row),
    .in_glyph_bits(in_glyph_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_color_0  (out_color_0),
    .out_color_1  (out_color_1),
    .out_color_2  (out_color_2),
    .out_color_3  (out_color_3),
    .out_color_4  (out_color_4),
    .out_color_5  (out_color_5),
    .out_color_6  (out_color_6),
    .out_color_7  (out_color_7),
    .out_last_row (out_last_row)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The cursor moves to the start of the next text row.
  function automatic void advance_text_row();
    cur_col = '0;
    cur_row = cur_row + 8'd1;
    if (cur_row >= rows_cfg) frame_full = 1'b1;
  endfunction

  // Apply one accepted transaction to the mirror and queue the glyph rows it draws.
  function automatic void render_transaction(input logic [1:0] op, input logic [7:0] code,
                                             input logic [3:0] grow, input logic [7:0] bits);
    pixel_row_t row_exp;
    int         r;
    int         px;
    case (op)
      OP_LOAD: begin
        if (grow < GLYPH_ROWS) begin
          font_mem[code][grow] = bits;
          if (rows_loaded[code] != '1) begin
            rows_loaded[code][grow] = 1'b1;
            if (rows_loaded[code] == '1) drawable_codes.push_back(code);
          end
        end
      end
      OP_RESTART: begin
        cur_col    = '0;
        cur_row    = '0;
        frame_full = 1'b0;
      end
      OP_DRAW: begin
        if (!frame_full && cur_row < rows_cfg) begin
          if (code == NEWLINE_CODE) begin
            advance_text_row();
          end else begin
            for (r = 0; r < GLYPH_ROWS; r++) begin
              row_exp.pixel_x = {cur_col, 3'b000};
              row_exp.pixel_y = 12'(int'(cur_row) * GLYPH_ROWS + r);
              for (px = 0; px < 8; px++)
                row_exp.color[px] = font_mem[code][r][7-px] ? fg_cfg : bg_cfg;
              row_exp.last_row = (r == GLYPH_ROWS - 1);
              pending_rows.push_back(row_exp);
            end
            cur_col = cur_col + 8'd1;
            if (cur_col >= cols_cfg || cur_col == 8'd0) advance_text_row();
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one transaction and hold it until the block accepts it.
  task automatic send_item(input logic [1:0] op, input logic [7:0] code,
                           input logic [3:0] grow, input logic [7:0] bits);
    if (idle_en && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_char_code  <= code;
    in_glyph_row  <= grow;
    in_glyph_bits <= bits;
    do @(posedge clk); while (in_ready !== 1'b1);
    render_transaction(op, code, grow, bits);
    items_sent++;
  endtask

  // Load all glyph rows of one character; row r comes from byte r of the pattern.
  task automatic load_glyph(input logic [7:0] code, input logic [95:0] pattern);
    int r;
    for (r = 0; r < GLYPH_ROWS; r++)
      send_item(OP_LOAD, code, 4'(r), pattern[r*8 +: 8]);
  endtask

  task automatic draw_char(input logic [7:0] code);
    send_item(OP_DRAW, code, 4'($urandom), 8'($urandom));
  endtask

  // Stop offering and wait until every queued glyph row has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Registers only change while the block is idle.
  task automatic set_layout(input logic [7:0] cols, input logic [7:0] rows,
                            input logic [31:0] fg, input logic [31:0] bg);
    wait_drained();
    put_reg(CFG_TEXT_COLUMNS, {24'd0, cols});
    put_reg(CFG_TEXT_ROWS, {24'd0, rows});
    put_reg(CFG_FG_COLOR, fg);
    put_reg(CFG_BG_COLOR, bg);
    cfg_wr_en <= 1'b0;
    cols_cfg = cols;
    rows_cfg = rows;
    fg_cfg   = fg;
    bg_cfg   = bg;
  endtask

  // Glyph extremes, ignored loads and the unused operation under reset settings.
  task automatic test_glyph_draw();
    load_glyph(8'd0, 96'hE718_FF00_8040_2010_0804_0201);
    load_glyph(8'hFF, 96'hFF00_8001_AA55_0FF0_3CC3_7E81);
    send_item(OP_LOAD, 8'd0, 4'hF, 8'hFF);
    send_item(OP_LOAD, 8'hFF, 4'd12, 8'h00);
    send_item(OP_UNUSED, 8'hFF, 4'hF, 8'hFF);
    draw_char(8'd0);
    draw_char(8'hFF);
  endtask

  task automatic test_newline_restart();
    draw_char(NEWLINE_CODE);
    draw_char(8'd0);
    send_item(OP_RESTART, 8'hFF, 4'hF, 8'hFF);
    draw_char(8'hFF);
  endtask

  // Full screen, zero sizes, largest sizes and a cursor left beyond the column count.
  task automatic test_config_extremes();
    set_layout(8'd2, 8'd1, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_RESTART, 8'd0, 4'd0, 8'd0);
    draw_char(8'd0);
    draw_char(8'hFF);
    draw_char(8'd0);
    draw_char(NEWLINE_CODE);
    send_item(OP_RESTART, 8'd0, 4'd0, 8'd0);
    draw_char(8'hFF);
    set_layout(8'd0, 8'd255, 32'h1234_5678, 32'h8765_4321);
    draw_char(8'd0);
    draw_char(8'hFF);
    set_layout(RST_TEXT_COLUMNS, 8'd0, 32'hFFFF_FFFF, 32'h0);
    draw_char(8'd0);
    draw_char(NEWLINE_CODE);
    set_layout(8'd255, 8'd255, $urandom, $urandom);
    send_item(OP_RESTART, 8'd0, 4'd0, 8'd0);
    repeat (4) draw_char(8'd0);
    set_layout(8'd3, 8'd255, $urandom, $urandom);
    draw_char(8'hFF);
    draw_char(8'd0);
    set_layout(RST_TEXT_COLUMNS, RST_TEXT_ROWS, RST_FG_COLOR, RST_BG_COLOR);
  endtask

  // The receiver stalls for a long stretch while characters keep coming.
  task automatic test_output_holdoff();
    send_item(OP_RESTART, 8'd0, 4'd0, 8'd0);
    hold_request = 1'b1;
    repeat (10) draw_char($urandom_range(0, 1) ? 8'hFF : 8'd0);
    wait_drained();
  endtask

  // Random layouts, then mostly drawing of loaded glyphs with some noise.
  task automatic test_random_text();
    int         counted;
    int         phase;
    int         pick;
    logic [7:0] cols;
    logic [7:0] rows;
    logic [3:0] grow;
    counted = 0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       cols = 8'd0;
        1:       cols = 8'd1;
        2:       cols = 8'd255;
        default: cols = 8'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 4))
        0:       rows = 8'd0;
        1:       rows = 8'd1;
        2:       rows = 8'd255;
        default: rows = 8'($urandom_range(1, 5));
      endcase
      set_layout(cols, rows,
                 ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'($urandom),
                 ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom));
      // One phase runs with neither side idling.
      idle_en = (phase != 2);
      if (phase == 0) begin
        repeat (6) load_glyph(8'($urandom), {$urandom, $urandom, $urandom});
        counted += 6 * GLYPH_ROWS;
      end
      while (counted < (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          draw_char(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
          counted++;
        end else if (pick < 63) begin
          draw_char(NEWLINE_CODE);
          counted++;
        end else if (pick < 70) begin
          send_item(OP_RESTART, 8'($urandom), 4'($urandom), 8'($urandom));
          counted++;
        end else if (pick < 82) begin
          grow = 4'($urandom);
          send_item(OP_LOAD, 8'($urandom), grow, 8'($urandom));
          if (grow < GLYPH_ROWS) counted++;
        end else if (pick < 88) begin
          send_item(OP_UNUSED, 8'($urandom), 4'($urandom), 8'($urandom));
        end else begin
          load_glyph(8'($urandom), {$urandom, $urandom, $urandom});
          counted += GLYPH_ROWS;
        end
      end
    end
    idle_en = 1'b1;
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !(idle_en && $urandom_range(0, 99) < 7);
    end
  end

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("Mismatch in %s at %0t: expected %h, got %h", field, $time, want, got);
  endfunction

  // Compare each accepted result transaction with the oldest predicted glyph row.
  always @(posedge clk) begin : row_checker
    pixel_row_t want;
    pixel_row_t got;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      got.pixel_x  = out_pixel_x;
      got.pixel_y  = out_pixel_y;
      got.color    = {out_color_7, out_color_6, out_color_5, out_color_4,
                      out_color_3, out_color_2, out_color_1, out_color_0};
      got.last_row = out_last_row;
      if (pending_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected glyph row at %0t: pixel_x %0d, pixel_y %0d",
                   $time, got.pixel_x, got.pixel_y);
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (got.pixel_x !== want.pixel_x)
          note_mismatch("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
        if (got.pixel_y !== want.pixel_y)
          note_mismatch("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
        for (int px = 0; px < 8; px++)
          if (got.color[px] !== want.color[px])
            note_mismatch($sformatf("color_%0d", px), want.color[px], got.color[px]);
        if (got.last_row !== want.last_row)
          note_mismatch("last_row", 32'(want.last_row), 32'(got.last_row));
      end
    end
  end

  // Upper bound on the run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d glyph rows pending",
             cycle_count, pending_rows.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_glyph_draw();
    test_newline_restart();
    test_config_extremes();
    test_output_holdoff();
    test_random_text();
    wait_drained();
    $display("Checked %0d glyph rows from %0d input transactions over directed cases,",
             rows_checked, items_sent);
    $display("an output hold-off and %0d random layouts; %0d mismatches.",
             RANDOM_PHASES, mismatch_count);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/btr_pkg.sv
rtl/btr_ctrl.sv
rtl/btr_datapath.sv
rtl/bitmap_text_renderer.sv
dv/tb.sv
